// ===== rtl/query_value_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// Query value extractor assertion macros
// Concurrent assertion shorthands used by the extractor top level.
// ----------------------------------------------------------------------------
`ifndef QUERY_VALUE_EXTRACTOR_ASSERT_SVH
`define QUERY_VALUE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define QVE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define QVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qve_pkg.sv =====
// ----------------------------------------------------------------------------
// qve_pkg
// Shared types, character codes and decode helpers of the query extractor.
// ----------------------------------------------------------------------------
package qve_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_LEN_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;

    // Defaults for top-level parameters
    localparam int DEF_MAX_KEY_BYTES = 8;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Character codes
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_KEY,
        PH_SKIP,
        PH_EMIT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } esc_t;

    // One parsed step: up to two results
    typedef struct packed {
        logic [7:0] b0;
        logic       v0;
        logic [7:0] b1;
        logic       two;
        logic       found;
        logic       last;
    } qve_rec_t;

    // Queue status toward both sides
    typedef struct packed {
        logic empty;
        logic full;
    } qve_qstat_t;

    // '+' reads as a space
    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        plain_byte = (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // {valid, value} of one hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        hex_digit = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            hex_digit = {1'b1, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            hex_digit = {1'b1, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            hex_digit = {1'b1, d[3:0]};
        end
    endfunction

    // Two-digit escape; a bad first digit gives 0, a bad second the first
    function automatic logic [7:0] hex_decode(input logic [7:0] c1, input logic [7:0] c2);
        logic [4:0] h1;
        logic [4:0] h2;
        h1 = hex_digit(c1);
        h2 = hex_digit(c2);
        if (!h1[4])
            hex_decode = 8'h00;
        else if (!h2[4])
            hex_decode = {4'h0, h1[3:0]};
        else
            hex_decode = {h1[3:0], h2[3:0]};
    endfunction

endpackage

// ===== rtl/qve_parser.sv =====
// ----------------------------------------------------------------------------
// qve_parser
// Front end: holds the key registers, walks the target one byte per
// transaction and turns each byte into a record of up to two results.
// ----------------------------------------------------------------------------
module qve_parser
    import qve_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_target,
    output logic                  rec_push,
    output qve_rec_t              rec
);

    localparam int POS_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [7:0]           key_bytes_reg [MAX_KEY_BYTES];
    logic [KEY_LEN_W-1:0] key_length_reg;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             mis_reg, mis_next;
    esc_t             esc_reg, esc_next;
    logic [7:0]       first_reg, first_next;

    logic [POS_W-1:0] eff_len;
    logic [7:0]       key_byte;
    logic [1:0]       nb;
    logic [7:0]       bb0;
    logic [7:0]       bb1;
    logic             fin;
    logic             fnd;
    logic             matches_cur;
    logic             matches_mid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_KEY_BYTES; i++)
                key_bytes_reg[i] <= 8'h00;
            key_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_TEXT:
                begin
                    for (int i = 0; i < MAX_KEY_BYTES; i++)
                        key_bytes_reg[i] <= cfg_data[8*i +: 8];
                end
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Oversized length clamps to the key storage
    assign eff_len = (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                     POS_W'(MAX_KEY_BYTES) : POS_W'(key_length_reg);
    assign key_byte = key_bytes_reg[pos_reg[KIDX_W-1:0]];

    // Per-byte parse step
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        mis_next    = mis_reg;
        esc_next    = esc_reg;
        first_next  = first_reg;
        nb          = 2'd0;
        bb0         = 8'h00;
        bb1         = 8'h00;
        fin         = 1'b0;
        fnd         = 1'b0;
        matches_cur = !mis_reg && (pos_reg == eff_len);

        case (phase_reg)
            PH_SEEK:
            begin
                if (in_byte == CH_QUEST)
                begin
                    phase_next = PH_KEY;
                    pos_next   = '0;
                    mis_next   = 1'b0;
                end
            end
            PH_KEY:
            begin
                if (in_byte == CH_AMP)
                begin
                    if (matches_cur)
                    begin
                        fin        = 1'b1;
                        fnd        = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        pos_next = '0;
                        mis_next = 1'b0;
                    end
                end
                else if (in_byte == CH_EQ)
                begin
                    if (matches_cur)
                    begin
                        phase_next = PH_EMIT;
                        esc_next   = ESC_NONE;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                else if (!mis_reg && (pos_reg < eff_len) && (in_byte == key_byte))
                    pos_next = pos_reg + POS_W'(1);
                else
                    mis_next = 1'b1;
            end
            PH_SKIP:
            begin
                if (in_byte == CH_AMP)
                begin
                    phase_next = PH_KEY;
                    pos_next   = '0;
                    mis_next   = 1'b0;
                end
            end
            PH_EMIT:
            begin
                if (in_byte == CH_AMP)
                begin
                    // pending short escape goes out literally
                    case (esc_reg)
                        ESC_PCT:
                        begin
                            bb0 = CH_PCT;
                            nb  = 2'd1;
                        end
                        ESC_DIGIT:
                        begin
                            bb0 = CH_PCT;
                            bb1 = plain_byte(first_reg);
                            nb  = 2'd2;
                        end
                        default: ;
                    endcase
                    esc_next   = ESC_NONE;
                    fin        = 1'b1;
                    fnd        = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    case (esc_reg)
                        ESC_NONE:
                        begin
                            if (in_byte == CH_PCT)
                                esc_next = ESC_PCT;
                            else
                            begin
                                bb0 = plain_byte(in_byte);
                                nb  = 2'd1;
                            end
                        end
                        ESC_PCT:
                        begin
                            first_next = in_byte;
                            esc_next   = ESC_DIGIT;
                        end
                        default:
                        begin
                            bb0      = hex_decode(first_reg, in_byte);
                            nb       = 2'd1;
                            esc_next = ESC_NONE;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        matches_mid = !mis_next && (pos_next == eff_len);

        // End of target closes an open answer
        if (end_of_target && !fin && (phase_next != PH_DONE))
        begin
            case (phase_next)
                PH_EMIT:
                begin
                    case (esc_next)
                        ESC_PCT:
                        begin
                            bb0 = CH_PCT;
                            nb  = 2'd1;
                        end
                        ESC_DIGIT:
                        begin
                            bb0 = CH_PCT;
                            bb1 = plain_byte(first_next);
                            nb  = 2'd2;
                        end
                        default: ;
                    endcase
                    fnd = 1'b1;
                end
                PH_KEY:  fnd = matches_mid && (eff_len != '0);
                default: fnd = 1'b0;
            endcase
            fin = 1'b1;
        end

        // Record toward the back end; a bare result when no byte is out
        rec.b0    = (nb != 2'd0) ? bb0 : 8'h00;
        rec.v0    = (nb != 2'd0);
        rec.b1    = bb1;
        rec.two   = (nb == 2'd2);
        rec.found = (nb != 2'd0) ? 1'b1 : fnd;
        rec.last  = fin;
        rec_push  = accept && ((nb != 2'd0) || fin);
    end

    // Parse state; every end of target returns to the start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            pos_reg   <= '0;
            mis_reg   <= 1'b0;
            esc_reg   <= ESC_NONE;
            first_reg <= 8'h00;
        end
        else if (accept)
        begin
            if (end_of_target)
            begin
                phase_reg <= PH_SEEK;
                pos_reg   <= '0;
                mis_reg   <= 1'b0;
                esc_reg   <= ESC_NONE;
                first_reg <= 8'h00;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                mis_reg   <= mis_next;
                esc_reg   <= esc_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

// ===== rtl/qve_queue.sv =====
// ----------------------------------------------------------------------------
// qve_queue
// Short record queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
module qve_queue
    import qve_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qve_rec_t   push_data,
    input  logic       pop,
    output qve_rec_t   head,
    output qve_qstat_t qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qve_rec_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slots_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== rtl/qve_emitter.sv =====
// ----------------------------------------------------------------------------
// qve_emitter
// Back end: presents the queued records one result at a time.
// ----------------------------------------------------------------------------
module qve_emitter
    import qve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qve_rec_t   head,
    input  qve_qstat_t qstat,
    input  logic       pop,
    output logic       q_pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       found,
    output logic       last
);

    logic half_reg;
    logic take;

    assign empty = qstat.empty;
    assign take  = pop && !qstat.empty;
    assign q_pop = take && (!head.two || half_reg);

    // Result mux: first or second half of the head record
    always_comb
    begin
        if (half_reg)
        begin
            out_byte   = head.b1;
            byte_valid = 1'b1;
            found      = head.found;
            last       = head.last;
        end
        else
        begin
            out_byte   = head.b0;
            byte_valid = head.v0;
            found      = head.found;
            last       = head.last && !head.two;
        end
    end

    // Half select for two-result records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= 1'b0;
        else if (take)
            half_reg <= head.two && !half_reg;
    end

endmodule

// ===== rtl/query_value_extractor.sv =====
// ----------------------------------------------------------------------------
// query_value_extractor
// Finds a configured key in the query of a request target and streams its
// percent-decoded value.
// Input: push in_byte/end_of_target while full is low, one byte a cycle.
// Config: cfg_valid with cfg_index (0 key_text, 1 key_length) and cfg_data;
//   cfg_ready is always high; write only while idle.
// Results: while empty is low the oldest result sits on out_byte,
//   byte_valid, found and last; pop takes it.
// Each result is registered in the record queue before it reaches the outputs.
// Throughput: one byte per cycle unless full; a two-result byte holds the
//   output for two pops, and the record queue absorbs the difference.
// Each target ends in exactly one result with last high.
// Reset clears the parse state, the queue and the key registers.
// If pop stays low the queue fills and full stalls the input.
// ----------------------------------------------------------------------------
`include "query_value_extractor_assert.svh"

module query_value_extractor
    import qve_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_target,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic                  found,
    output logic                  last
);

    qve_rec_t   rec;
    qve_rec_t   head;
    qve_qstat_t qstat;
    logic       rec_push;
    logic       q_pop;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign full      = qstat.full;
    assign accept    = push && !qstat.full;

    // Front end
    qve_parser #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_target (end_of_target),
        .rec_push      (rec_push),
        .rec           (rec)
    );

    // Record queue
    qve_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec),
        .pop       (q_pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Back end
    qve_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .q_pop      (q_pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .found      (found),
        .last       (last)
    );

    // Assertions
    `QVE_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, qstat.full, !rec_push, "push into full queue")
    `QVE_ASSERT_IMPL(a_bare_is_last, clk, rst_n, !empty && !byte_valid, last, "bare result not last")
    `QVE_ASSERT_IMPL(a_two_has_bytes, clk, rst_n, rec_push && rec.two, rec.v0, "no first byte")
    `QVE_ASSERT_IMPL(a_rec_needs_accept, clk, rst_n, rec_push, accept, "record without byte")

endmodule

// ===== verif/tb_query_value_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_query_value_extractor
// Self-checking bench for the query value extractor. Request targets are
// fed byte by byte through the input queue port. A local model of the
// parser predicts each decoded value byte and the closing answer. Every
// popped result is compared against the oldest prediction. Both sides
// idle at random, and the key registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_query_value_extractor;
    import qve_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int KEY_BYTES    = DEF_MAX_KEY_BYTES;
    localparam int ITEM_TARGET  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RX_HOLD_LEN  = 300;
    localparam int MAX_REPORTS  = 10;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // One byte of a request target
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } target_byte_t;

    // One predicted result
    typedef struct packed {
        logic [7:0] value;
        logic       has_byte;
        logic       found;
        logic       last;
    } answer_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_KEY_TEXT;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  push          = 1'b0;
    logic                  full;
    logic [7:0]            in_byte       = 8'h00;
    logic                  end_of_target = 1'b0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic                  found;
    logic                  last;

    // Stimulus and scoreboard storage
    target_byte_t pending_bytes[$];
    answer_t      expected_answers[$];
    answer_t      step_answers[$];

    // Shadow of the key registers
    logic [63:0] key_text_cfg = '0;
    logic [3:0]  key_len_cfg  = '0;

    // Predicted parse state
    phase_t     parse_ph  = PH_SEEK;
    logic [3:0] key_pos   = '0;
    logic       key_bad   = 1'b0;
    esc_t       esc_ph    = ESC_NONE;
    logic [7:0] hex_first = '0;

    int           fail_count   = 0;
    int           sent_bytes   = 0;
    int           tx_wait      = 0;
    int           rx_wait      = 0;
    int           rx_hold_left = 0;
    logic         tx_burst     = 1'b0;
    logic         rx_burst     = 1'b0;
    logic         rx_hold_arm  = 1'b0;
    target_byte_t next_item;
    answer_t      want;

    query_value_extractor #(
        .MAX_KEY_BYTES (KEY_BYTES),
        .QUEUE_DEPTH   (DEF_QUEUE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_target (end_of_target),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .found         (found),
        .last          (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic logic [3:0] key_len_eff();
        return (key_len_cfg > KEY_BYTES) ? 4'(KEY_BYTES) : key_len_cfg;
    endfunction

    function automatic logic key_hit();
        return !key_bad && key_pos == key_len_eff();
    endfunction

    function automatic logic [7:0] to_plain(logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Digit value, or -1 when not a hex digit
    function automatic int hex_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void add_answer(logic [7:0] b, logic v, logic f);
        answer_t a;
        a.value    = b;
        a.has_byte = v;
        a.found    = f;
        a.last     = 1'b0;
        step_answers = {step_answers, a};
    endfunction

    // An escape cut short by the end of the value goes out literally
    function automatic void flush_escape();
        if (esc_ph == ESC_PCT)
            add_answer(CH_PCT, 1'b1, 1'b1);
        else if (esc_ph == ESC_DIGIT)
        begin
            add_answer(CH_PCT, 1'b1, 1'b1);
            add_answer(to_plain(hex_first), 1'b1, 1'b1);
        end
        esc_ph = ESC_NONE;
    endfunction

    // Advance the model by one accepted byte and queue its results
    function automatic void predict_answers(logic [7:0] c, logic eot);
        logic       closed;
        logic       hit;
        int         h1;
        int         h2;
        logic [7:0] v;
        closed = 1'b0;
        hit    = 1'b0;
        step_answers.delete();
        sent_bytes++;

        case (parse_ph)
            PH_SEEK:
            begin
                if (c == CH_QUEST)
                begin
                    parse_ph = PH_KEY;
                    key_pos  = '0;
                    key_bad  = 1'b0;
                end
            end
            PH_KEY:
            begin
                if (c == CH_AMP)
                begin
                    if (key_hit())
                    begin
                        closed   = 1'b1;
                        hit      = 1'b1;
                        parse_ph = PH_DONE;
                    end
                    else
                    begin
                        key_pos = '0;
                        key_bad = 1'b0;
                    end
                end
                else if (c == CH_EQ)
                begin
                    if (key_hit())
                    begin
                        parse_ph = PH_EMIT;
                        esc_ph   = ESC_NONE;
                    end
                    else
                        parse_ph = PH_SKIP;
                end
                else if (!key_bad && key_pos < key_len_eff() &&
                         c == key_text_cfg[8 * key_pos[2:0] +: 8])
                    key_pos++;
                else
                    key_bad = 1'b1;
            end
            PH_SKIP:
            begin
                if (c == CH_AMP)
                begin
                    parse_ph = PH_KEY;
                    key_pos  = '0;
                    key_bad  = 1'b0;
                end
            end
            PH_EMIT:
            begin
                if (c == CH_AMP)
                begin
                    flush_escape();
                    closed   = 1'b1;
                    hit      = 1'b1;
                    parse_ph = PH_DONE;
                end
                else if (esc_ph == ESC_NONE)
                begin
                    if (c == CH_PCT)
                        esc_ph = ESC_PCT;
                    else
                        add_answer(to_plain(c), 1'b1, 1'b1);
                end
                else if (esc_ph == ESC_PCT)
                begin
                    hex_first = c;
                    esc_ph    = ESC_DIGIT;
                end
                else
                begin
                    h1 = hex_value(hex_first);
                    h2 = hex_value(c);
                    if (h1 < 0)
                        v = 8'h00;
                    else if (h2 < 0)
                        v = 8'(h1);
                    else
                        v = 8'(h1 * 16 + h2);
                    add_answer(v, 1'b1, 1'b1);
                    esc_ph = ESC_NONE;
                end
            end
            default: ;
        endcase

        // Target ends before an answer went out
        if (eot && !closed && parse_ph != PH_DONE)
        begin
            if (parse_ph == PH_EMIT)
            begin
                flush_escape();
                hit = 1'b1;
            end
            else if (parse_ph == PH_KEY)
                hit = key_hit() && key_len_eff() != 0;
            else
                hit = 1'b0;
            closed = 1'b1;
        end

        if (closed)
        begin
            if (step_answers.size() == 0)
                add_answer(8'h00, 1'b0, hit);
            step_answers[step_answers.size() - 1].last = 1'b1;
        end
        foreach (step_answers[i])
            expected_answers = {expected_answers, step_answers[i]};

        if (eot)
        begin
            parse_ph  = PH_SEEK;
            key_pos   = '0;
            key_bad   = 1'b0;
            esc_ph    = ESC_NONE;
            hex_first = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Small alphabet so random keys collide with the configured one
    function automatic logic [7:0] key_char();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [63:0] letters_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++)
            k[8 * i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
        return k;
    endfunction

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'h30 + 8'(r);
        if (r < 16) return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 16);
    endfunction

    // Value bytes lean on escapes, digits and the hex range edges
    function automatic logic [7:0] value_char();
        logic [7:0] edges [6];
        edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        case ($urandom_range(0, 9))
            0, 1:    return CH_PCT;
            2, 3:    return hex_char();
            4:       return CH_PLUS;
            5:       return 8'($urandom_range(0, 255));
            6:       return CH_EQ;
            7:       return edges[$urandom_range(0, 5)];
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(0, 255));
            4:          return CH_QUEST;
            5:          return CH_AMP;
            6:          return CH_EQ;
            7:          return CH_PCT;
            default:    return key_char();
        endcase
    endfunction

    function automatic void queue_bytes(logic [7:0] bytes[$]);
        target_byte_t t;
        foreach (bytes[i])
        begin
            t.data = bytes[i];
            t.eot  = (i == bytes.size() - 1);
            pending_bytes = {pending_bytes, t};
        end
    endfunction

    function automatic void queue_string(string s);
        logic [7:0] bytes[$];
        for (int i = 0; i < s.len(); i++)
            bytes = {bytes, 8'(s[i])};
        queue_bytes(bytes);
    endfunction

    // One random target: mostly well-formed queries, some noise
    function automatic void queue_target();
        logic [7:0] bytes[$];
        logic [7:0] b;
        int         kind;
        int         klen;
        int         tweak;
        int         flip_at;
        klen = key_len_eff();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 12))
                bytes = {bytes, noise_char()};
        end
        else
        begin
            // Path in front of the query
            repeat ($urandom_range(0, 3))
            begin
                b = key_char();
                bytes = {bytes, ((b == CH_QUEST) ? 8'h2F : b)};
            end
            if (kind != 1)
                bytes = {bytes, CH_QUEST};
            for (int p = 0; p < $urandom_range(0, 4); p++)
            begin
                if (p > 0)
                    bytes = {bytes, CH_AMP};
                case ($urandom_range(0, 5))
                    0, 1, 2:
                    begin
                        for (int j = 0; j < klen; j++)
                            bytes = {bytes, key_text_cfg[8 * j +: 8]};
                    end
                    3:
                    begin
                        // Near miss: shortened, lengthened or one bit off
                        tweak   = $urandom_range(0, 2);
                        flip_at = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
                        for (int j = 0; j < klen; j++)
                        begin
                            b = key_text_cfg[8 * j +: 8];
                            if (tweak == 2 && j == flip_at)
                                b ^= 8'h01 << $urandom_range(0, 7);
                            if (!(tweak == 0 && j == klen - 1))
                                bytes = {bytes, b};
                        end
                        if (tweak == 1)
                            bytes = {bytes, key_char()};
                    end
                    default:
                    begin
                        repeat ($urandom_range(0, 4))
                            bytes = {bytes, key_char()};
                    end
                endcase
                if ($urandom_range(0, 5) != 0)
                begin
                    bytes = {bytes, CH_EQ};
                    repeat ($urandom_range(0, 8))
                        bytes = {bytes, value_char()};
                end
            end
            if ($urandom_range(0, 4) == 0)
                bytes = {bytes, CH_AMP};
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    bytes = {bytes, noise_char()};
        end
        if (bytes.size() == 0)
            bytes = {bytes, noise_char()};
        queue_bytes(bytes);
    endfunction

    // ------------------------------------------------------------------------
    // Sequencing tasks
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_TEXT)
            key_text_cfg = data;
        else if (idx == CFG_KEY_LENGTH)
            key_len_cfg = data[3:0];
        @(negedge clk);
    endtask

    // Sender drained, every result popped, then a drain pause
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || push || expected_answers.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push          <= 1'b0;
            in_byte       <= 8'h00;
            end_of_target <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (push && !full)
                predict_answers(in_byte, end_of_target);
            // Slot is free once the held byte is taken
            if (!push || !full)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    push <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_item = pending_bytes.pop_front();
                    in_byte       <= next_item.data;
                    end_of_target <= next_item.eot;
                    push          <= 1'b1;
                    tx_wait = tx_burst ? 0 : pick_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            rx_wait      = 0;
            rx_hold_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_answers.size() == 0)
                    note_failure($sformatf(
                        "unexpected result: byte %02h valid %0b found %0b last %0b",
                        out_byte, byte_valid, found, last));
                else
                begin
                    want = expected_answers.pop_front();
                    if (out_byte !== want.value || byte_valid !== want.has_byte ||
                        found !== want.found || last !== want.last)
                        note_failure($sformatf(
                            {"mismatch: expected byte %02h valid %0b found %0b last %0b,",
                             " got byte %02h valid %0b found %0b last %0b"},
                            want.value, want.has_byte, want.found, want.last,
                            out_byte, byte_valid, found, last));
                end
            end

            // Long hold-off so the result queue backs up into the input
            if (rx_hold_arm)
            begin
                rx_hold_left = RX_HOLD_LEN;
                rx_hold_arm  = 1'b0;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                pop <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                rx_wait = rx_burst ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] len_word;
        logic [3:0]            len_val;
        int                    phase_idx;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: key "ab", first character in the low byte
        cfg_write(CFG_KEY_TEXT, 64'h0000_0000_0000_6261);
        cfg_write(CFG_KEY_LENGTH, 64'd2);
        // Plus, full escape, bad first digit, bad second digit, lone '%' at the end
        queue_string("?ab=+%4A%G1%2G%");
        // Key matched at end of target with no value
        queue_string("?c&ab");
        // Escape cut by '&', then a byte after the answer
        queue_string("?ab=%4&z");
        // No query at all, byte extremes
        queue_bytes('{8'h00, 8'hFF});
        wait_idle();

        // Random phases, each under its own key setting
        phase_idx = 0;
        while (sent_bytes < ITEM_TARGET)
        begin
            len_word = {$urandom(), $urandom()};
            case (phase_idx % 6)
                0:
                begin
                    cfg_write(CFG_KEY_TEXT, letters_key());
                    len_val = 4'($urandom_range(1, 8));
                end
                1:
                begin
                    cfg_write(CFG_KEY_TEXT, {$urandom(), $urandom()});
                    len_val = 4'd0;
                end
                2:
                begin
                    cfg_write(CFG_KEY_TEXT, letters_key());
                    len_val = 4'd8;
                end
                3:
                begin
                    // Length beyond the key width
                    cfg_write(CFG_KEY_TEXT, letters_key());
                    len_val = 4'($urandom_range(9, 15));
                end
                4:
                begin
                    cfg_write(CFG_KEY_TEXT, ((phase_idx / 6) % 2 == 0) ? '0 : '1);
                    len_val = 4'($urandom_range(1, 8));
                end
                default:
                begin
                    cfg_write(CFG_KEY_TEXT, {$urandom(), $urandom()});
                    len_val = 4'($urandom_range(1, 8));
                end
            endcase
            len_word[3:0] = len_val;
            cfg_write(CFG_KEY_LENGTH, len_word);
            if (phase_idx == 0)
                cfg_write(CFG_UNMAPPED, {$urandom(), $urandom()});

            if (phase_idx == 1)
            begin
                // Sender streams while the receiver holds off
                tx_burst    = 1'b1;
                rx_burst    = 1'b0;
                rx_hold_arm = 1'b1;
            end
            else
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end

            repeat (30) queue_target();
            wait_idle();
            phase_idx++;
        end

        if (fail_count == 0)
            $display("tb_query_value_extractor OK");
        else
            $display("tb_query_value_extractor NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_query_value_extractor NOT OK");
        $finish;
    end

endmodule
